@@ sv/ps2mt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int BYTE_WIDTH  = 8;
    localparam int BTN_WIDTH   = 3;

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic [BYTE_WIDTH-1:0]  byte_t;
    typedef logic [BTN_WIDTH-1:0]   btn_t;

    localparam coord_t MAX_X_RESET = COORD_WIDTH'(319);
    localparam coord_t MAX_Y_RESET = COORD_WIDTH'(199);
    localparam coord_t POS_X_RESET = COORD_WIDTH'(160);
    localparam coord_t POS_Y_RESET = COORD_WIDTH'(100);

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MAX_X = 1'b0,
        CFG_MAX_Y = 1'b1
    } cfg_index_t;

    typedef struct packed {
        coord_t     cursor_x;
        coord_t     cursor_y;
        btn_t       button_bits;
        logic       packet_done;
    } result_t;

endpackage

@@ sv/ps2mt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_if
// Valid/ready channels: received mouse bytes in, cursor results out.
// ----------------------------------------------------------------------------
interface ps2mt_byte_if
    import ps2mt_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
    modport monitor (input valid, input rx_byte, input ready);
endinterface

interface ps2mt_cursor_if
    import ps2mt_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t cursor_x;
    coord_t cursor_y;
    btn_t   button_bits;
    logic   packet_done;

    modport source (output valid, output cursor_x, output cursor_y,
                    output button_bits, output packet_done, input ready);
    modport sink (input valid, input cursor_x, input cursor_y,
                  input button_bits, input packet_done, output ready);
    modport monitor (input valid, input cursor_x, input cursor_y,
                     input button_bits, input packet_done, input ready);
endinterface

@@ sv/ps2mt_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_in_reg
// Input register for received bytes; takes a beat every cycle the next
// stage drains.
// ----------------------------------------------------------------------------
module ps2mt_in_reg
    import ps2mt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ps2mt_byte_if.sink   up,
    output logic         dn_valid,
    output byte_t        dn_byte,
    input  logic         dn_ready
);

    logic  valid_reg;
    byte_t byte_reg;

    assign up.ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            byte_reg <= up.rx_byte;
        end
    end

endmodule

@@ sv/ps2mt_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_track
// Packet phase, held bytes, cursor position and clamp limits. Builds the
// result for the byte in the input register and updates state when it moves.
// ----------------------------------------------------------------------------
module ps2mt_track
    import ps2mt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  cfg_index_t cfg_index,
    input  coord_t     cfg_data,
    input  logic       fire,
    input  byte_t      rx_byte,
    output result_t    res
);

    localparam int SUM_WIDTH = COORD_WIDTH + 2;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    phase_t phase_reg, phase_next;
    byte_t  byte0_reg;
    byte_t  byte1_reg;
    coord_t pos_x_reg, pos_y_reg;
    btn_t   buttons_reg;
    coord_t max_x_reg, max_y_reg;

    logic signed [BYTE_WIDTH-1:0] dx, dy;
    logic signed [SUM_WIDTH-1:0]  sum_x, sum_y;
    coord_t new_x, new_y;
    logic   last_byte;

    function automatic coord_t clamp(input logic signed [SUM_WIDTH-1:0] v, input coord_t lim);
        coord_t r;
        if (v[SUM_WIDTH-1])
        begin
            r = '0;
        end
        else if (v[SUM_WIDTH-2:0] > {1'b0, lim})
        begin
            r = lim;
        end
        else
        begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    // phase 3 never occurs; it is handled as the third byte
    assign last_byte = (phase_reg != PH_FIRST) && (phase_reg != PH_SECOND);

    assign dx    = byte1_reg;
    assign dy    = rx_byte;
    assign sum_x = signed'({2'b00, pos_x_reg}) + SUM_WIDTH'(dx);
    assign sum_y = signed'({2'b00, pos_y_reg}) - SUM_WIDTH'(dy);   // screen Y grows down
    assign new_x = clamp(sum_x, max_x_reg);
    assign new_y = clamp(sum_y, max_y_reg);

    always_comb
    begin
        case (phase_reg)
            PH_FIRST:  phase_next = PH_SECOND;
            PH_SECOND: phase_next = PH_THIRD;
            default:   phase_next = PH_FIRST;
        endcase

        if (last_byte)
        begin
            res.cursor_x    = new_x;
            res.cursor_y    = new_y;
            res.button_bits = byte0_reg[BTN_WIDTH-1:0];
            res.packet_done = 1'b1;
        end
        else
        begin
            res.cursor_x    = pos_x_reg;
            res.cursor_y    = pos_y_reg;
            res.button_bits = buttons_reg;
            res.packet_done = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            pos_x_reg   <= POS_X_RESET;
            pos_y_reg   <= POS_Y_RESET;
            buttons_reg <= '0;
            max_x_reg   <= MAX_X_RESET;
            max_y_reg   <= MAX_Y_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MAX_X: max_x_reg <= cfg_data;
                    CFG_MAX_Y: max_y_reg <= cfg_data;
                    default:   ;
                endcase
            end
            if (fire)
            begin
                phase_reg <= phase_next;
                if (last_byte)
                begin
                    pos_x_reg   <= new_x;
                    pos_y_reg   <= new_y;
                    buttons_reg <= byte0_reg[BTN_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (phase_reg == PH_FIRST))
        begin
            byte0_reg <= rx_byte;
        end
        if (fire && (phase_reg == PH_SECOND))
        begin
            byte1_reg <= rx_byte;
        end
    end

endmodule

@@ sv/ps2mt_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_out_reg
// Result register driving the cursor channel.
// ----------------------------------------------------------------------------
module ps2mt_out_reg
    import ps2mt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    input  result_t         up_res,
    output logic            up_ready,
    ps2mt_cursor_if.source  dn
);

    logic    valid_reg;
    result_t res_reg;

    assign up_ready       = !valid_reg || dn.ready;
    assign dn.valid       = valid_reg;
    assign dn.cursor_x    = res_reg.cursor_x;
    assign dn.cursor_y    = res_reg.cursor_y;
    assign dn.button_bits = res_reg.button_bits;
    assign dn.packet_done = res_reg.packet_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            res_reg <= up_res;
        end
    end

endmodule

@@ sv/ps2mt_mouse_packet_cursor_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_unit
// PS/2 mouse three-byte packet decoder with a clamped cursor position.
// ----------------------------------------------------------------------------
// Takes one mouse byte per cycle and returns one result beat per byte: the
// cursor position, the buttons and a flag set on the third byte of a packet.
// A byte is held in the input register while the phase, delta add and clamp
// logic forms its result, which lands in the output register; a new byte is
// taken every cycle as long as the output side drains. The phase counter and
// position registers update in the same cycle as the byte moves to the output
// register. Write max_x and max_y only while no bytes are in flight; a new
// limit applies from the next completed packet. No packet sync check is made
// on the first byte.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_unit
    import ps2mt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  cfg_index_t      cfg_index,
    input  coord_t          cfg_data,
    ps2mt_byte_if.sink      byte_in,
    ps2mt_cursor_if.source  cursor_out
);

    logic    stg_valid;
    byte_t   stg_byte;
    logic    stg_ready;
    result_t stg_res;

    ps2mt_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .up       (byte_in),
        .dn_valid (stg_valid),
        .dn_byte  (stg_byte),
        .dn_ready (stg_ready)
    );

    ps2mt_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (stg_valid && stg_ready),
        .rx_byte   (stg_byte),
        .res       (stg_res)
    );

    ps2mt_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stg_valid),
        .up_res   (stg_res),
        .up_ready (stg_ready),
        .dn       (cursor_out)
    );

endmodule

@@ sv/ps2mt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_checker
// Port-level checks on the cursor tracker: packet framing and cursor hold.
// ----------------------------------------------------------------------------
module ps2mt_checker
    import ps2mt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cursor_valid,
    input  logic   cursor_ready,
    input  coord_t cursor_x,
    input  coord_t cursor_y,
    input  btn_t   button_bits,
    input  logic   packet_done
);

    logic [1:0] beat_cnt_reg;
    coord_t     last_x_reg, last_y_reg;
    btn_t       last_btn_reg;
    logic       out_beat;

    assign out_beat = cursor_valid && cursor_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_cnt_reg <= '0;
            last_x_reg   <= POS_X_RESET;
            last_y_reg   <= POS_Y_RESET;
            last_btn_reg <= '0;
        end
        else if (out_beat)
        begin
            beat_cnt_reg <= (beat_cnt_reg == 2'd2) ? 2'd0 : beat_cnt_reg + 2'd1;
            last_x_reg   <= cursor_x;
            last_y_reg   <= cursor_y;
            last_btn_reg <= button_bits;
        end
    end

    // every third beat closes a packet
    a_packet_framing: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> (packet_done == (beat_cnt_reg == 2'd2)))
        else $error("packet_done out of step with beat count");

    // cursor and buttons only move on a packet-closing beat
    a_hold_between_packets: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && !packet_done) |->
            (cursor_x == last_x_reg && cursor_y == last_y_reg
             && button_bits == last_btn_reg))
        else $error("cursor changed on a non-final byte");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_valid && !cursor_ready) |=> cursor_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_valid && !cursor_ready) |=>
            ($stable(cursor_x) && $stable(cursor_y)
             && $stable(button_bits) && $stable(packet_done)))
        else $error("result payload changed while stalled");

endmodule

bind ps2_mouse_packet_cursor_tracker_unit ps2mt_checker u_ps2mt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cursor_valid (cursor_out.valid),
    .cursor_ready (cursor_out.ready),
    .cursor_x     (cursor_out.cursor_x),
    .cursor_y     (cursor_out.cursor_y),
    .button_bits  (cursor_out.button_bits),
    .packet_done  (cursor_out.packet_done)
);

@@ sim/ps2_mouse_packet_cursor_tracker_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_unit_test
// Self-checking bench for the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
// Mouse bytes are queued by a stimulus thread and sent by a clocked driver.
// Each accepted byte runs through a local cursor tracker that predicts the
// result beat. A clocked monitor checks every result beat field by field
// against the oldest prediction. The run walks through several clamp limits,
// including 0 and 4095, and through phases with no gaps, source gaps, sink
// stalls or both. Limits are only written once the pipeline has drained.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_unit_test;
    import ps2mt_pkg::*;

    localparam int CLK_PERIOD        = 4;
    localparam int SETTLE_CYCLES     = 4;
    localparam int NUM_PHASES        = 7;
    localparam int PACKETS_PER_PHASE = 76;
    localparam int CYCLE_LIMIT       = 200000;

    // position of the next byte within a packet
    typedef enum logic [1:0] {
        SLOT_STATUS = 2'd0,
        SLOT_DX     = 2'd1,
        SLOT_DY     = 2'd2
    } pkt_slot_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    cfg_index_t cfg_index;
    coord_t     cfg_data;

    ps2mt_byte_if   byte_ch();
    ps2mt_cursor_if cursor_ch();

    ps2_mouse_packet_cursor_tracker_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_in    (byte_ch),
        .cursor_out (cursor_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // tracker copy: framing, held packet bytes, cursor, buttons, limits
    pkt_slot_t trk_slot   = SLOT_STATUS;
    byte_t     trk_status = '0;
    byte_t     trk_dx     = '0;
    coord_t    trk_x      = POS_X_RESET;
    coord_t    trk_y      = POS_Y_RESET;
    btn_t      trk_btn    = '0;
    coord_t    lim_x      = MAX_X_RESET;
    coord_t    lim_y      = MAX_Y_RESET;

    byte_t   mouse_bytes[$];
    result_t cursor_due[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    function automatic coord_t clamp_coord(int v, coord_t lim);
        if (v < 0)
            return '0;
        if (v > int'(lim))
            return lim;
        return coord_t'(v);
    endfunction

    function automatic result_t track_mouse_byte(byte_t b);
        result_t r;
        int      nx;
        int      ny;
        r.packet_done = 1'b0;
        case (trk_slot)
            SLOT_STATUS:
            begin
                trk_status = b;
                trk_slot   = SLOT_DX;
            end
            SLOT_DX:
            begin
                trk_dx   = b;
                trk_slot = SLOT_DY;
            end
            default:
            begin
                nx = int'(trk_x) + int'($signed(trk_dx));
                // screen Y grows downward, so dy is subtracted
                ny = int'(trk_y) - int'($signed(b));
                trk_x   = clamp_coord(nx, lim_x);
                trk_y   = clamp_coord(ny, lim_y);
                trk_btn = trk_status[BTN_WIDTH-1:0];
                trk_slot = SLOT_STATUS;
                r.packet_done = 1'b1;
            end
        endcase
        r.cursor_x    = trk_x;
        r.cursor_y    = trk_y;
        r.button_bits = trk_btn;
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_cursor(result_t got);
        result_t want;
        if (cursor_due.size() == 0)
        begin
            flag_mismatch("result beat with no pending byte");
            return;
        end
        want = cursor_due.pop_front();
        if (got.cursor_x !== want.cursor_x)
            flag_mismatch($sformatf("cursor_x got %0d want %0d", got.cursor_x, want.cursor_x));
        if (got.cursor_y !== want.cursor_y)
            flag_mismatch($sformatf("cursor_y got %0d want %0d", got.cursor_y, want.cursor_y));
        if (got.button_bits !== want.button_bits)
            flag_mismatch($sformatf("button_bits got %0h want %0h",
                                    got.button_bits, want.button_bits));
        if (got.packet_done !== want.packet_done)
            flag_mismatch($sformatf("packet_done got %0b want %0b",
                                    got.packet_done, want.packet_done));
    endtask

    // driver: one beat per handshake, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid   <= 1'b0;
            byte_ch.rx_byte <= '0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                cursor_due.push_back(track_mouse_byte(byte_ch.rx_byte));
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (mouse_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    byte_ch.valid   <= 1'b1;
                    byte_ch.rx_byte <= mouse_bytes.pop_front();
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random sink stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_ch.ready <= 1'b0;
        end
        else
        begin
            if (cursor_ch.valid && cursor_ch.ready)
                check_cursor('{cursor_ch.cursor_x, cursor_ch.cursor_y,
                               cursor_ch.button_bits, cursor_ch.packet_done});
            cursor_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ps2_mouse_packet_cursor_tracker_unit_test: FAIL");
            $finish;
        end
    end

    // wait until nothing is queued, in flight or outstanding
    task automatic settle();
        @(negedge clk);
        while (mouse_bytes.size() != 0 || byte_ch.valid || cursor_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(cfg_index_t idx, coord_t val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MAX_X)
            lim_x = val;
        else
            lim_y = val;
    endtask

    task automatic queue_packet(byte_t status, byte_t dx, byte_t dy);
        mouse_bytes.push_back(status);
        mouse_bytes.push_back(dx);
        mouse_bytes.push_back(dy);
    endtask

    // mostly large steps one way so the cursor runs into both clamp limits
    function automatic byte_t drift_delta(int heading);
        int mag;
        if ($urandom_range(99) < 85)
        begin
            mag = $urandom_range(64, 127);
            return byte_t'(heading * mag);
        end
        return byte_t'($urandom_range(255));
    endfunction

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_MAX_X;
        cfg_data        = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        cursor_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: delta extremes, all button bits, clamping at both ends
        src_idle_pct   = 30;
        sink_stall_pct = 30;
        queue_packet(8'h00, 8'h00, 8'h00);
        queue_packet(8'hFF, 8'h7F, 8'h7F);
        queue_packet(8'h05, 8'h7F, 8'h80);
        queue_packet(8'h02, 8'h80, 8'h7F);
        queue_packet(8'hF8, 8'h81, 8'h01);

        // pause inside a packet so non-final bytes are seen on an idle block
        settle();
        mouse_bytes.push_back(8'h03);
        settle();
        mouse_bytes.push_back(8'h7F);
        settle();
        mouse_bytes.push_back(8'h81);

        // lower the limits below the current cursor between packets
        queue_packet(8'h01, 8'h7F, 8'h80);
        settle();
        write_limit(CFG_MAX_X, 12'd100);
        write_limit(CFG_MAX_Y, 12'd50);
        queue_packet(8'h06, 8'h00, 8'h00);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    write_limit(CFG_MAX_X, 12'hFFF);
                    write_limit(CFG_MAX_Y, 12'hFFF);
                end
                1:
                begin
                    write_limit(CFG_MAX_X, 12'h000);
                    write_limit(CFG_MAX_Y, 12'h000);
                end
                2:
                begin
                    write_limit(CFG_MAX_X, 12'hFFF);
                    write_limit(CFG_MAX_Y, 12'd1);
                end
                3:
                begin
                    write_limit(CFG_MAX_X, coord_t'($urandom));
                    write_limit(CFG_MAX_Y, coord_t'($urandom));
                end
                4:
                begin
                    write_limit(CFG_MAX_X, 12'd1);
                    write_limit(CFG_MAX_Y, 12'hFFF);
                end
                5:
                begin
                    write_limit(CFG_MAX_X, MAX_X_RESET);
                    write_limit(CFG_MAX_Y, MAX_Y_RESET);
                end
                default:
                begin
                    write_limit(CFG_MAX_X, coord_t'($urandom_range(8, 700)));
                    write_limit(CFG_MAX_Y, coord_t'($urandom_range(8, 700)));
                end
            endcase
            case (ph % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 73;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 73;
                end
                default:
                begin
                    src_idle_pct   = 30;
                    sink_stall_pct = 30;
                end
            endcase
            for (int k = 0; k < PACKETS_PER_PHASE; k++)
            begin
                int heading;
                heading = (k < PACKETS_PER_PHASE * 3 / 5) ? 1 : -1;
                // stray bytes break framing for a while; 1 + 2 restores it
                if (k == PACKETS_PER_PHASE / 2)
                    mouse_bytes.push_back(byte_t'($urandom));
                if (k == PACKETS_PER_PHASE * 3 / 4)
                begin
                    mouse_bytes.push_back(byte_t'($urandom));
                    mouse_bytes.push_back(byte_t'($urandom));
                end
                if ($urandom_range(99) < 10)
                    queue_packet(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
                else
                    queue_packet(byte_t'($urandom_range(255)), drift_delta(heading),
                                 drift_delta(-heading));
            end
        end

        settle();
        if (error_count == 0)
            $display("ps2_mouse_packet_cursor_tracker_unit_test: PASS");
        else
            $display("ps2_mouse_packet_cursor_tracker_unit_test: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
sv/ps2mt_pkg.sv
sv/ps2mt_if.sv
sv/ps2mt_in_reg.sv
sv/ps2mt_track.sv
sv/ps2mt_out_reg.sv
sv/ps2mt_mouse_packet_cursor_tracker_unit.sv
sv/ps2mt_checker.sv
sim/ps2_mouse_packet_cursor_tracker_unit_test.sv
